>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks clocked on clk with active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// types and constants shared by the nearest neighbour tour unit
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int MAX_CITIES = 16;
  localparam int CITY_W     = $clog2(MAX_CITIES);
  localparam int COUNT_W    = 5;
  localparam int DIST_W     = 16;
  localparam int TOTAL_W    = 20;
  localparam int ADDR_W     = 2 * CITY_W;

  typedef logic [CITY_W-1:0]     city_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [MAX_CITIES-1:0] mask_t;

  // request codes carried on in_func
  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_TOUR  = 1'b1
  } func_t;

  // request to the distance memory
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    dist_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

endpackage

>>> rtl/core/nnt_dist_ram.sv
// ----------------------------------------------------------------------------
// nnt_dist_ram
// distance store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module nnt_dist_ram (
  input  logic             clk,
  input  nnt_pkg::mem_req_t mem_req,
  output nnt_pkg::dist_t   rd_data
);
  import nnt_pkg::*;

  dist_t mem [2**ADDR_W];
  dist_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) begin
      rd_data_r <= mem[mem_req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/nearest_neighbour_tour_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_unit
// greedy nearest neighbour tour over a symmetric distance matrix
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): in_func low writes in_distance for the
//   city pair (in_row_city, in_col_city) in both directions, one request per
//   cycle, no result. in_func high runs a tour from city 0 over cfg city count.
//   output channel (out_valid / out_stall): one request per tour edge, the
//   closing edge back to city 0 carries out_last.
//   cfg_wr_en / cfg_wr_data set the city count; the user must write it only
//   while the unit is idle, as the unit itself does not enforce this.
// run
//   every step scans n matrix entries through the single read port of the
//   distance memory, one entry per cycle with the read data registered, and
//   a move state follows. in_stall stays high for the whole run.
// reset
//   rst_n clears control state and sets the city count to 16; the matrix
//   keeps no reset and holds garbage until written.
// stall
//   a held result keeps its payload; the scan goes on and only the next
//   result waits for the output register to drain.
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_unit (
  input  logic            clk,
  input  logic            rst_n,
  // request input
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_func,
  input  nnt_pkg::city_t  in_row_city,
  input  nnt_pkg::city_t  in_col_city,
  input  nnt_pkg::dist_t  in_distance,
  // result output
  output logic            out_valid,
  input  logic            out_stall,
  output nnt_pkg::city_t  out_from_city,
  output nnt_pkg::city_t  out_to_city,
  output nnt_pkg::dist_t  out_edge_cost,
  output nnt_pkg::total_t out_total_cost,
  output logic            out_last,
  // configuration
  input  logic            cfg_wr_en,
  input  nnt_pkg::count_t cfg_wr_data
);
  import nnt_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_SCAN      = 5'b00010,
    S_MOVE      = 5'b00100,
    S_CLOSE_RD  = 5'b01000,
    S_CLOSE_OUT = 5'b10000
  } state_t;

  // the matrix is symmetric: both directions share one entry
  function automatic addr_t pair_addr(city_t a, city_t b);
    if (a >= b) begin
      return {a, b};
    end else begin
      return {b, a};
    end
  endfunction

  // running total saturates at its full width
  function automatic total_t sat_add(total_t t, dist_t d);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, t} + {{(TOTAL_W + 1 - DIST_W){1'b0}}, d};
    if (sum[TOTAL_W]) begin
      return '1;
    end else begin
      return sum[TOTAL_W-1:0];
    end
  endfunction

  state_t   state_r,   state_nxt;
  count_t   city_count_r;
  city_t    n_last_r,  n_last_nxt;   // index of the highest city in the run
  city_t    cur_r,     cur_nxt;
  mask_t    visited_r, visited_nxt;
  total_t   total_r,   total_nxt;
  city_t    step_r,    step_nxt;
  city_t    j_r,       j_nxt;        // scan issue index
  logic     iss_r,     iss_nxt;
  logic     rd_vld_r;                // read data of rd_j_r is present
  city_t    rd_j_r;
  logic     have_r,    have_nxt;
  city_t    best_r,    best_nxt;
  dist_t    best_d_r,  best_d_nxt;

  logic     out_valid_r;
  city_t    out_from_r, out_from_nxt;
  city_t    out_to_r,   out_to_nxt;
  dist_t    out_edge_r, out_edge_nxt;
  total_t   out_total_r, out_total_nxt;
  logic     out_last_r, out_last_nxt;
  logic     out_load;
  logic     out_free;

  logic     in_acc;
  mem_req_t mem_req;
  dist_t    rd_data;

  nnt_dist_ram u_dist_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    n_last_nxt    = n_last_r;
    cur_nxt       = cur_r;
    visited_nxt   = visited_r;
    total_nxt     = total_r;
    step_nxt      = step_r;
    j_nxt         = j_r;
    iss_nxt       = iss_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    out_load      = 1'b0;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_edge_nxt  = out_edge_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    mem_req         = '0;
    mem_req.wr_addr = pair_addr(in_row_city, in_col_city);
    mem_req.wr_data = in_distance;
    mem_req.rd_addr = pair_addr(cur_r, j_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_WRITE) begin
            mem_req.wr_en = 1'b1;
          end else begin
            visited_nxt = mask_t'(1);
            cur_nxt     = '0;
            total_nxt   = '0;
            step_nxt    = '0;
            j_nxt       = '0;
            have_nxt    = 1'b0;
            // zero counts as one city, larger counts clip to the maximum
            if (city_count_r == '0) begin
              n_last_nxt = '0;
            end else if (city_count_r > count_t'(MAX_CITIES)) begin
              n_last_nxt = city_t'(MAX_CITIES - 1);
            end else begin
              n_last_nxt = city_t'(city_count_r - 1'b1);
            end
            if (n_last_nxt == '0) begin
              state_nxt = S_CLOSE_RD;
            end else begin
              state_nxt = S_SCAN;
              iss_nxt   = 1'b1;
            end
          end
        end
      end

      S_SCAN: begin
        mem_req.rd_en = iss_r;
        if (iss_r) begin
          if (j_r == n_last_r) begin
            iss_nxt = 1'b0;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
        if (rd_vld_r) begin
          // ties go to the later, higher index
          if (!visited_r[rd_j_r] && (!have_r || rd_data <= best_d_r)) begin
            have_nxt   = 1'b1;
            best_nxt   = rd_j_r;
            best_d_nxt = rd_data;
          end
          if (rd_j_r == n_last_r) begin
            state_nxt = S_MOVE;
          end
        end
      end

      S_MOVE: begin
        if (!have_r) begin
          state_nxt = S_CLOSE_RD;
        end else if (out_free) begin
          out_load      = 1'b1;
          total_nxt     = sat_add(total_r, best_d_r);
          out_from_nxt  = cur_r;
          out_to_nxt    = best_r;
          out_edge_nxt  = best_d_r;
          out_total_nxt = total_nxt;
          out_last_nxt  = 1'b0;
          cur_nxt       = best_r;
          visited_nxt   = visited_r | (mask_t'(1) << best_r);
          if (city_t'(step_r + 1'b1) == n_last_r) begin
            state_nxt = S_CLOSE_RD;
          end else begin
            step_nxt  = step_r + 1'b1;
            j_nxt     = '0;
            iss_nxt   = 1'b1;
            have_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_CLOSE_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = pair_addr(cur_r, '0);
        state_nxt       = S_CLOSE_OUT;
      end

      S_CLOSE_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          total_nxt     = sat_add(total_r, rd_data);
          out_from_nxt  = cur_r;
          out_to_nxt    = '0;
          out_edge_nxt  = rd_data;
          out_total_nxt = total_nxt;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      city_count_r <= count_t'(MAX_CITIES);
      n_last_r     <= '0;
      cur_r        <= '0;
      visited_r    <= '0;
      total_r      <= '0;
      step_r       <= '0;
      j_r          <= '0;
      iss_r        <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_j_r       <= '0;
      have_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      n_last_r  <= n_last_nxt;
      cur_r     <= cur_nxt;
      visited_r <= visited_nxt;
      total_r   <= total_nxt;
      step_r    <= step_nxt;
      j_r       <= j_nxt;
      iss_r     <= iss_nxt;
      rd_vld_r  <= (state_r == S_SCAN) && mem_req.rd_en;
      rd_j_r    <= j_r;
      have_r    <= have_nxt;
      if (cfg_wr_en) begin
        city_count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    best_d_r    <= best_d_nxt;
    out_from_r  <= out_from_nxt;
    out_to_r    <= out_to_nxt;
    out_edge_r  <= out_edge_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_from_city  = out_from_r;
  assign out_to_city    = out_to_r;
  assign out_edge_cost  = out_edge_r;
  assign out_total_cost = out_total_r;
  assign out_last       = out_last_r;

  // checks
  `ASSERT_NEXT(a_run_start, in_acc && in_func,
    (visited_r == mask_t'(1)) && (total_r == '0) && (cur_r == '0),
    "run did not restart from city zero")
  `ASSERT_NEXT(a_last_to_idle, out_load && out_last_nxt, state_r == S_IDLE,
    "closing edge did not end the run")
  `ASSERT_CLK(a_scan_data, !rd_vld_r || (state_r == S_SCAN),
    "scan read data outside the scan")
  `ASSERT_CLK(a_best_unvisited, !((state_r == S_MOVE) && have_r) || !visited_r[best_r],
    "chosen city already visited")

endmodule
